@@ rtl/hpt_pkg.sv @@
// Shared constants and types for the histogram peak height threshold block.
package hpt_pkg;

    localparam int DW = 16;
    localparam int NB_W = 6;
    localparam int NUM_W = DW + NB_W;
    localparam int NQ_W = 5;
    localparam logic [NQ_W-1:0] NQ_BIN = 5'd6;
    localparam logic [NQ_W-1:0] NQ_OUT = 5'd16;
    localparam logic [NB_W-1:0] NUM_BINS_RESET = 6'd20;
    localparam int MAX_ITEMS_DEF = 1024;
    localparam int MAX_BINS_DEF = 64;

    typedef enum logic [3:0] {
        B_IDLE,
        B_H_RD,
        B_DIV_GO,
        B_DIV_WAIT,
        B_BIN_RD,
        B_BIN_WR,
        B_SCAN_RD,
        B_SCAN_CMP,
        B_WALK_SET,
        B_WALK_RD,
        B_WALK_CMP,
        B_FDIV_GO,
        B_FDIV_WAIT,
        B_OUT
    } back_state_t;

endpackage

@@ rtl/hpt_if.sv @@
// Channel interfaces for heights, results and the bin count register.
interface hpt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] height;
    logic        last;
    modport source (output valid, output height, output last, input ready);
    modport sink (input valid, input height, input last, output ready);
endinterface

interface hpt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] title_height;
    logic        degenerate;
    modport source (output valid, output title_height, output degenerate, input ready);
    modport sink (input valid, input title_height, input degenerate, output ready);
endinterface

interface hpt_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] num_bins;
    modport source (output valid, output num_bins, input ready);
    modport sink (input valid, input num_bins, output ready);
endinterface

@@ rtl/hpt_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module hpt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hpt_pkg::NUM_W-1:0] num,
    input  logic [hpt_pkg::DW-1:0]    den,
    input  logic [hpt_pkg::NQ_W-1:0]  nq,
    output logic                      done,
    output logic [hpt_pkg::DW-1:0]    quo
);
    import hpt_pkg::*;

    localparam int SH_W = 2 * DW - 1;

    logic              busy_reg, busy_next;
    logic [NQ_W-1:0]   cnt_reg, cnt_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [SH_W-1:0]   rem_ext;

    assign rem_ext = SH_W'(rem_reg);
    assign done = busy_reg && (cnt_reg == '0);
    assign quo = quo_reg;

    // Load operands on start, then subtract the shifted divisor once per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        sh_next = sh_reg;
        quo_next = quo_reg;
        if (!busy_reg && start)
        begin
            busy_next = 1'b1;
            cnt_next = nq;
            rem_next = num;
            sh_next = SH_W'(den) << (nq - NQ_W'(1));
            quo_next = '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (rem_ext >= sh_reg)
            begin
                rem_next = rem_reg - NUM_W'(sh_reg);
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            sh_next = sh_reg >> 1;
            cnt_next = cnt_reg - NQ_W'(1);
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg <= sh_next;
        quo_reg <= quo_next;
    end

endmodule

@@ rtl/hpt_queue.sv @@
// Two-entry job queue between the loading front end and the histogram back end.
module hpt_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         pop_valid
);
    logic [W-1:0] slot_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   fill_reg;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_data = slot_reg[rp_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push && push_ready)
                wp_reg <= ~wp_reg;
            if (pop && pop_valid)
                rp_reg <= ~rp_reg;
            if ((push && push_ready) && !(pop && pop_valid))
                fill_reg <= fill_reg + 2'd1;
            else if (!(push && push_ready) && (pop && pop_valid))
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // Store job data
    always_ff @(posedge clk)
    begin
        if (push && push_ready)
            slot_reg[wp_reg] <= push_data;
    end

endmodule

@@ rtl/hpt_front.sv @@
// Front end: takes heights, stores them, tracks min and max, posts one job per set.
module hpt_front #(
    parameter int MAX_ITEMS = hpt_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BINS = hpt_pkg::MAX_BINS_DEF,
    localparam int AW = $clog2(MAX_ITEMS),
    localparam int CNT_W = $clog2(MAX_ITEMS + 1),
    localparam int JW = 2 * hpt_pkg::DW + CNT_W + hpt_pkg::NB_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    hpt_in_if.sink                 items,
    hpt_cfg_if.sink                cfg,
    output logic                   job_push,
    output logic [JW-1:0]          job_data,
    input  logic                   job_ready,
    input  logic                   mem_release,
    input  logic [AW-1:0]          rd_addr,
    output logic [hpt_pkg::DW-1:0] rd_data
);
    import hpt_pkg::*;

    localparam int CAP_I = (MAX_BINS - 1 > 63) ? 63 : MAX_BINS - 1;
    localparam logic [NB_W-1:0] NB_CAP = NB_W'(CAP_I);

    logic [DW-1:0]    mem [MAX_ITEMS];
    logic [DW-1:0]    rd_data_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    min_reg, max_reg;
    logic             lock_reg;
    logic [NB_W-1:0]  nb_reg, nb_sat;
    logic             acc, stored;
    logic [DW-1:0]    min_new, max_new, range_new;

    assign items.ready = !lock_reg && job_ready;
    assign cfg.ready = 1'b1;
    assign acc = items.valid && items.ready;
    assign stored = (cnt_reg < CNT_W'(MAX_ITEMS));
    assign rd_data = rd_data_reg;

    // Saturate the bin count to the supported range
    always_comb
    begin
        if (cfg.num_bins == '0)
            nb_sat = NB_W'(1);
        else if (cfg.num_bins > NB_CAP)
            nb_sat = NB_CAP;
        else
            nb_sat = cfg.num_bins;
    end

    // Fold the incoming height into the running extremes
    always_comb
    begin
        min_new = min_reg;
        max_new = max_reg;
        if (stored && items.height < min_reg)
            min_new = items.height;
        if (stored && items.height > max_reg)
            max_new = items.height;
        range_new = max_new - min_new;
    end

    assign job_push = acc && items.last;
    assign job_data = {min_new, range_new, (stored ? cnt_reg + CNT_W'(1) : cnt_reg),
                       nb_reg, (range_new == '0)};

    // Track set state and hold the store while the back end reads it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            lock_reg <= 1'b0;
            nb_reg <= NUM_BINS_RESET;
        end
        else
        begin
            if (cfg.valid)
                nb_reg <= nb_sat;
            if (mem_release)
                lock_reg <= 1'b0;
            if (acc)
            begin
                if (items.last)
                begin
                    cnt_reg <= '0;
                    min_reg <= '1;
                    max_reg <= '0;
                    lock_reg <= 1'b1;
                end
                else
                begin
                    if (stored)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    min_reg <= min_new;
                    max_reg <= max_new;
                end
            end
        end
    end

    // Write heights, read for the binning pass
    always_ff @(posedge clk)
    begin
        if (acc && stored)
            mem[cnt_reg[AW-1:0]] <= items.height;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ rtl/hpt_back.sv @@
// Back end: bins the stored heights, finds the peak label, computes the threshold.
module hpt_back #(
    parameter int MAX_ITEMS = hpt_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BINS = hpt_pkg::MAX_BINS_DEF,
    localparam int AW = $clog2(MAX_ITEMS),
    localparam int CNT_W = $clog2(MAX_ITEMS + 1),
    localparam int BW = $clog2(MAX_BINS),
    localparam int JW = 2 * hpt_pkg::DW + CNT_W + hpt_pkg::NB_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [JW-1:0]          job_data,
    input  logic                   job_valid,
    output logic                   job_pop,
    output logic                   mem_release,
    output logic [AW-1:0]          rd_addr,
    input  logic [hpt_pkg::DW-1:0] rd_data,
    hpt_out_if.source              results
);
    import hpt_pkg::*;

    back_state_t      state_reg, state_next;
    logic [DW-1:0]    min_reg, min_next;
    logic [DW-1:0]    range_reg, range_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NB_W-1:0]  nb_reg, nb_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [BW-1:0]    baddr_reg, baddr_next;
    logic [BW-1:0]    label_reg, label_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic [DW-1:0]    title_reg, title_next;
    logic             deg_reg, deg_next;
    logic [NUM_W-1:0] prod_reg, prod_next;

    logic [CNT_W-1:0] bmem [MAX_BINS];
    logic [CNT_W-1:0] brd_reg;
    logic [MAX_BINS-1:0] bvalid_reg;
    logic             bclear, bwrite;
    logic [CNT_W-1:0] bval;

    logic [DW-1:0]    j_min, j_range;
    logic [CNT_W-1:0] j_cnt;
    logic [NB_W-1:0]  j_nb;
    logic             j_deg;
    logic [BW-1:0]    nbb;

    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DW-1:0]    div_den, div_q;
    logic [NQ_W-1:0]  div_nq;
    logic [BW-1:0]    qbin;

    assign {j_min, j_range, j_cnt, j_nb, j_deg} = job_data;
    assign nbb = BW'(nb_reg);
    assign bval = bvalid_reg[baddr_reg] ? brd_reg : '0;
    assign qbin = (div_q > DW'(nb_reg)) ? nbb : BW'(div_q);
    assign rd_addr = idx_reg[AW-1:0];

    hpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .nq    (div_nq),
        .done  (div_done),
        .quo   (div_q)
    );

    // Next state and datapath
    always_comb
    begin
        state_next = state_reg;
        min_next = min_reg;
        range_next = range_reg;
        cnt_next = cnt_reg;
        nb_next = nb_reg;
        idx_next = idx_reg;
        baddr_next = baddr_reg;
        label_next = label_reg;
        best_next = best_reg;
        title_next = title_reg;
        deg_next = deg_reg;
        prod_next = prod_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    min_next = j_min;
                    range_next = j_range;
                    cnt_next = j_cnt;
                    nb_next = j_nb;
                    idx_next = '0;
                    if (j_deg)
                    begin
                        title_next = j_min;
                        deg_next = 1'b1;
                        state_next = B_OUT;
                    end
                    else
                    begin
                        deg_next = 1'b0;
                        state_next = B_H_RD;
                    end
                end
            end
            B_H_RD:
                state_next = B_DIV_GO;
            B_DIV_GO:
            begin
                prod_next = NUM_W'(rd_data - min_reg) * NUM_W'(nb_reg);
                state_next = B_DIV_WAIT;
            end
            B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    baddr_next = qbin;
                    state_next = B_BIN_RD;
                end
            end
            B_BIN_RD:
                state_next = B_BIN_WR;
            B_BIN_WR:
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == cnt_reg)
                begin
                    baddr_next = '0;
                    state_next = B_SCAN_RD;
                end
                else
                begin
                    state_next = B_H_RD;
                end
            end
            B_SCAN_RD:
                state_next = B_SCAN_CMP;
            B_SCAN_CMP:
            begin
                if (baddr_reg == '0 || bval > best_reg)
                begin
                    best_next = bval;
                    label_next = baddr_reg;
                end
                if (baddr_reg == nbb)
                begin
                    state_next = B_WALK_SET;
                end
                else
                begin
                    baddr_next = baddr_reg + BW'(1);
                    state_next = B_SCAN_RD;
                end
            end
            B_WALK_SET:
            begin
                if (label_reg < nbb)
                begin
                    baddr_next = label_reg + BW'(1);
                    state_next = B_WALK_RD;
                end
                else
                begin
                    state_next = B_FDIV_GO;
                end
            end
            B_WALK_RD:
                state_next = B_WALK_CMP;
            B_WALK_CMP:
            begin
                if (best_reg > bval)
                begin
                    label_next = baddr_reg;
                    best_next = bval;
                    if (baddr_reg < nbb)
                    begin
                        baddr_next = baddr_reg + BW'(1);
                        state_next = B_WALK_RD;
                    end
                    else
                    begin
                        state_next = B_FDIV_GO;
                    end
                end
                else
                begin
                    state_next = B_FDIV_GO;
                end
            end
            B_FDIV_GO:
            begin
                prod_next = NUM_W'(NB_W'(label_reg)) * NUM_W'(range_reg);
                state_next = B_FDIV_WAIT;
            end
            B_FDIV_WAIT:
            begin
                if (div_done)
                begin
                    title_next = min_reg + div_q;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (results.ready)
                    state_next = B_IDLE;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        job_pop = 1'b0;
        mem_release = 1'b0;
        div_start = 1'b0;
        div_num = prod_reg;
        div_den = range_reg;
        div_nq = NQ_BIN;
        bclear = 1'b0;
        bwrite = 1'b0;
        results.valid = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                job_pop = job_valid;
                mem_release = job_valid && j_deg;
                bclear = job_valid;
            end
            B_DIV_WAIT:
                div_start = 1'b1;
            B_BIN_WR:
            begin
                bwrite = 1'b1;
                mem_release = (idx_reg + CNT_W'(1) == cnt_reg);
            end
            B_FDIV_WAIT:
            begin
                div_start = 1'b1;
                div_den = DW'(nb_reg);
                div_nq = NQ_OUT;
            end
            B_OUT:
                results.valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign results.title_height = title_reg;
    assign results.degenerate = deg_reg;

    // Advance state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            bvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (bclear)
                bvalid_reg <= '0;
            else if (bwrite)
                bvalid_reg[baddr_reg] <= 1'b1;
        end
    end

    // Hold job and search registers
    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        range_reg <= range_next;
        cnt_reg <= cnt_next;
        nb_reg <= nb_next;
        idx_reg <= idx_next;
        baddr_reg <= baddr_next;
        label_reg <= label_next;
        best_reg <= best_next;
        title_reg <= title_next;
        deg_reg <= deg_next;
        prod_reg <= prod_next;
    end

    // Bin count memory with registered read
    always_ff @(posedge clk)
    begin
        if (bwrite)
            bmem[baddr_reg] <= bval + CNT_W'(1);
        brd_reg <= bmem[baddr_reg];
    end

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV_WAIT && div_done) |-> (div_q <= DW'(nb_reg)))
        else $error("bin index exceeds bin count");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_BIN_WR) |-> (idx_reg < cnt_reg))
        else $error("binning pass ran past the stored heights");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (state_reg != B_IDLE))
        else $error("job taken without starting work");
    a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FDIV_GO) |-> (label_reg <= nbb))
        else $error("peak label beyond last bin");

endmodule

@@ rtl/histogram_peak_height_threshold.sv @@
// Top level of the histogram peak height threshold block.
//
// Heights arrive on the items channel, one per transaction; the transaction
// with last set closes the set. The cfg channel writes the bin count and is
// always ready; write it only while the block is idle. One result per set
// leaves on the results channel: the threshold height, or the minimum with
// degenerate set when all heights were equal.
// Loading accepts heights back to back while the height store is free and the
// job queue has room. After the last height the back end makes a binning pass
// that for each stored height does a memory read, a six-step divide and a bin
// count read-modify-write, then a peak scan over the bins, a short upward walk,
// and a final divide.
// A two-entry job queue sits between loading and binning; the front end takes
// the first height of the next set once the binning pass has released the
// height store, so a stalled results channel still lets the next set load.
// Reset clears counts, extremes and the job queue and sets the bin count to 20.
module histogram_peak_height_threshold #(
    parameter int MAX_ITEMS = hpt_pkg::MAX_ITEMS_DEF,
    parameter int MAX_BINS = hpt_pkg::MAX_BINS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hpt_in_if.sink    items,
    hpt_cfg_if.sink   cfg,
    hpt_out_if.source results
);
    import hpt_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int JW = 2 * DW + CNT_W + NB_W + 1;

    logic          push, push_ready, pop, pop_valid, mem_release;
    logic [JW-1:0] push_data, pop_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    hpt_front #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_BINS  (MAX_BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .cfg         (cfg),
        .job_push    (push),
        .job_data    (push_data),
        .job_ready   (push_ready),
        .mem_release (mem_release),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    hpt_queue #(
        .W (JW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    hpt_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_BINS  (MAX_BINS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_data    (pop_data),
        .job_valid   (pop_valid),
        .job_pop     (pop),
        .mem_release (mem_release),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .results     (results)
    );

endmodule
